>>> rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, constants and helpers shared by the delimiter field splitter.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int MAX_SEPARATOR = 8;
    localparam int OFFSET_BITS   = 16;
    localparam int SEP_BITS      = 8 * MAX_SEPARATOR;
    localparam int LEN_BITS      = 4;
    localparam int SHIFT_BITS    = LEN_BITS + 3;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SEP_BITS-1:0]    SEP_RESET = SEP_BITS'(44);
    localparam logic [LEN_BITS-1:0]    LEN_RESET = LEN_BITS'(1);

    typedef enum logic {
        CFG_SEP_BYTES  = 1'b0,
        CFG_SEP_LENGTH = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [15:0] field_offset;
        logic [15:0] field_length;
        logic        last_field;
    } t_out_item;

    // separator as seen by the match logic
    typedef struct packed {
        logic [SEP_BITS-1:0] bytes;
        logic [LEN_BITS-1:0] length;
    } t_sep_cfg;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + OFFSET_BITS'(1);
    endfunction

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [LEN_BITS-1:0] eff_length(input logic [LEN_BITS-1:0] l);
        if (l == '0) begin
            eff_length = LEN_BITS'(1);
        end else if (l > LEN_BITS'(MAX_SEPARATOR)) begin
            eff_length = LEN_BITS'(MAX_SEPARATOR);
        end else begin
            eff_length = l;
        end
    endfunction

    function automatic logic [SEP_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] l);
        logic [SEP_BITS-1:0] m;
        m = '0;
        for (int k = 0; k < MAX_SEPARATOR; k++) begin
            if (LEN_BITS'(k) < l) begin
                m[8*k +: 8] = 8'hff;
            end
        end
        len_mask = m;
    endfunction

endpackage

>>> rtl/dfs_match.sv
// ----------------------------------------------------------------------------
// dfs_match
// Window compare: the newest separator-length bytes against the separator.
// ----------------------------------------------------------------------------
module dfs_match (
    input  dfs_pkg::t_sep_cfg                   i_cfg,
    input  logic [dfs_pkg::SEP_BITS-1:0]        i_window,
    input  logic [dfs_pkg::OFFSET_BITS-1:0]     i_count,
    output logic                                o_match
);
    import dfs_pkg::*;

    logic [SHIFT_BITS-1:0] shift_amt;
    logic [SEP_BITS-1:0]   aligned;
    logic [SEP_BITS-1:0]   mask;

    always_comb begin
        // newest byte sits at the top, so drop the bytes older than the separator
        shift_amt = {LEN_BITS'(MAX_SEPARATOR) - i_cfg.length, 3'b000};
        aligned   = i_window >> shift_amt;
        mask      = len_mask(i_cfg.length);
        o_match   = (i_count >= OFFSET_BITS'(i_cfg.length))
                    && (((aligned ^ i_cfg.bytes) & mask) == '0);
    end

endmodule

>>> rtl/delimiter_field_splitter.sv
// ----------------------------------------------------------------------------
// delimiter_field_splitter
// Splits a byte stream into fields on a configured 1 to 8 byte separator.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_item  (t_in_item)
//  output    out        o_valid / i_stall    o_item  (t_out_item)
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one byte is taken every cycle unless a held result stalls the input; its
// field, if it closes one, appears in the result register on the next cycle.
// the window compare and counter updates are combinational, between the
// stream state and the result register. a held result stalls the input
// only while it is not taken. synchronous active-low reset clears the
// stream state and loads ',' as the separator with length one.
// ----------------------------------------------------------------------------
module delimiter_field_splitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  dfs_pkg::t_in_item             i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output dfs_pkg::t_out_item            o_item,
    input  logic                          i_cfg_we,
    input  dfs_pkg::t_cfg_index           i_cfg_index,
    input  logic [dfs_pkg::SEP_BITS-1:0]  i_cfg_data
);
    import dfs_pkg::*;

    logic [SEP_BITS-1:0]    r_sep;
    logic [LEN_BITS-1:0]    r_len;
    logic [SEP_BITS-1:0]    r_window;
    logic [OFFSET_BITS-1:0] r_count;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    t_sep_cfg               sep_cfg;
    logic [SEP_BITS-1:0]    n_window;
    logic [OFFSET_BITS-1:0] n_count;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] field_len;
    logic                   match;
    logic                   accept;
    logic                   emit;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    assign sep_cfg.bytes  = r_sep;
    assign sep_cfg.length = eff_length(r_len);

    always_comb begin
        n_window = {i_item.data_byte, r_window[SEP_BITS-1:8]};
        n_count  = sat_inc(r_count);
        n_pos    = sat_inc(r_pos);
        // a saturated count is reported as is
        if (match && (n_count != COUNT_MAX)) begin
            field_len = n_count - OFFSET_BITS'(sep_cfg.length);
        end else begin
            field_len = n_count;
        end
        emit = accept && (match || i_item.end_of_source);
    end

    dfs_match u_match (
        .i_cfg    (sep_cfg),
        .i_window (n_window),
        .i_count  (n_count),
        .o_match  (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
            r_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEP_BYTES:  r_sep <= i_cfg_data;
                CFG_SEP_LENGTH: r_len <= i_cfg_data[LEN_BITS-1:0];
                default:        r_len <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
            r_start  <= '0;
            r_pos    <= '0;
        end else if (accept) begin
            priority if (i_item.end_of_source) begin
                r_window <= '0;
                r_count  <= '0;
                r_start  <= '0;
                r_pos    <= '0;
            end else if (match) begin
                // separator bytes are never shared between matches
                r_window <= '0;
                r_count  <= '0;
                r_start  <= n_pos;
                r_pos    <= n_pos;
            end else begin
                r_window <= n_window;
                r_count  <= n_count;
                r_pos    <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item.field_offset <= 16'(r_start);
            r_out_item.field_length <= 16'(field_len);
            r_out_item.last_field   <= i_item.end_of_source;
        end
    end

endmodule

>>> rtl/dfs_checker.sv
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks for the delimiter field splitter, bound to the top level.
// ----------------------------------------------------------------------------
module dfs_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_stall,
    input  dfs_pkg::t_in_item   i_item,
    input  logic                o_valid,
    input  logic                i_stall,
    input  dfs_pkg::t_out_item  o_item
);
    import dfs_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output request changed while stalled");

    // the input only backs up behind an untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a pending result");

    // the end of a source always closes a field, marked as the last one
    a_end_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.end_of_source |=> o_valid && o_item.last_field)
        else $error("end of source gave no last field");

    // nothing is offered straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind delimiter_field_splitter dfs_checker u_dfs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
